// ===== hdl/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared types and constants for the graph split reachability block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsr_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VertW       = $clog2(MaxVertices);
  localparam int unsigned DepthW      = VertW + 1;
  localparam int unsigned CountW      = 7;

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [1:0] OP_DIVIDE   = 2'd2;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef logic [MaxVertices-1:0] row_t;
  typedef logic [VertW-1:0]       vert_t;

  // adjacency memory request
  typedef struct packed {
    logic  clear;
    logic  we;
    vert_t wr_addr;
    row_t  wr_data;
    logic  re;
    vert_t rd_addr;
  } adj_req_t;

endpackage

// ===== hdl/gsr_adj_mem.sv =====
// ----------------------------------------------------------------------------
// gsr_adj_mem
// Adjacency row memory with per-row valid bits; registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsr_adj_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gsr_pkg::adj_req_t req_i,
  output gsr_pkg::row_t    rd_row_o
);

  gsr_pkg::row_t mem_q [gsr_pkg::MaxVertices];
  gsr_pkg::row_t vld_q;
  gsr_pkg::row_t rd_q;
  logic          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // a row never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : '0;

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> (vld_q == '0))
    else $error("adjacency valid bits not cleared");

endmodule

// ===== hdl/gsr_ffs.sv =====
// ----------------------------------------------------------------------------
// gsr_ffs
// Find-first-set over a candidate row: lowest set index wins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsr_ffs (
  input  gsr_pkg::row_t  cand_i,
  output logic           found_o,
  output gsr_pkg::vert_t idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = gsr_pkg::MaxVertices - 1; i >= 0; i--) begin
      if (cand_i[i]) begin
        idx_o = gsr_pkg::VertW'(i);
      end
    end
  end

  assign found_o = |cand_i;

endmodule

// ===== hdl/graph_split_reachability.sv =====
// ----------------------------------------------------------------------------
// graph_split_reachability
// Adjacency matrix with clear, add-edge and depth-first split walk.
// ----------------------------------------------------------------------------
// A clear transaction empties the adjacency memory; an add-edge transaction
// does two read-modify-writes of the adjacency memory, none when an
// endpoint is out of range. A divide query walks depth first from the start
// vertex, one registered adjacency row read plus one find-first-set scan per
// step; each visited vertex is pushed and each dead end backtracks by a pop,
// and the walk waits while the output register is held. The slave side is
// not ready while a transaction is in work; results leave through an output
// register, with tlast on the final vertex.
`timescale 1ns / 1ps

module graph_split_reachability (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: operation[1:0], edge_first[7:2], edge_second[13:8],
  //        start_vertex[19:14], excluded_vertex[25:20], zero pad [31:26]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // tdata: vertex[5:0], zero pad [7:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EA_WR,
    ST_EB_RD,
    ST_EB_WR,
    ST_SCAN,
    ST_POP,
    ST_FIN
  } state_e;

  state_e st_q;

  logic [gsr_pkg::CountW-1:0] vcount_q;
  gsr_pkg::vert_t             ea_q, eb_q, pend_q, start_q, excl_q;
  gsr_pkg::row_t              visited_q, allowed_q, allowed_d;
  logic [gsr_pkg::DepthW-1:0] depth_q;
  logic [gsr_pkg::DepthW-1:0] pop_depth;

  gsr_pkg::vert_t stack_q [gsr_pkg::MaxVertices];
  gsr_pkg::vert_t stack_rd_q;
  logic           stk_we, stk_re;
  gsr_pkg::vert_t stk_waddr, stk_wdata, stk_raddr;

  logic           out_vld_q, out_last_q;
  gsr_pkg::vert_t out_vert_q;
  logic           out_free;

  gsr_pkg::adj_req_t req;
  gsr_pkg::row_t     rd_row, cand;
  logic              found;
  gsr_pkg::vert_t    w;

  logic [1:0]     in_op;
  gsr_pkg::vert_t in_a, in_b, in_start, in_excl;
  logic           s_acc, in_range, push, last_pop;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= gsr_pkg::CountW'(gsr_pkg::MaxVertices);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == gsr_pkg::REG_VERTEX_COUNT)) begin
      vcount_q <= pwdata[gsr_pkg::CountW-1:0];
    end
  end

  assign prdata = (paddr[2] == gsr_pkg::REG_VERTEX_COUNT)
                ? {{(32-gsr_pkg::CountW){1'b0}}, vcount_q} : '0;

  // ---------------- input decode ----------------
  assign in_op    = s_axis_tdata[1:0];
  assign in_a     = s_axis_tdata[7:2];
  assign in_b     = s_axis_tdata[13:8];
  assign in_start = s_axis_tdata[19:14];
  assign in_excl  = s_axis_tdata[25:20];

  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_range      = ({1'b0, in_a} < vcount_q) && ({1'b0, in_b} < vcount_q);

  always_comb begin
    for (int i = 0; i < gsr_pkg::MaxVertices; i++) begin
      allowed_d[i] = (gsr_pkg::CountW'(i) < vcount_q) &&
                     (gsr_pkg::VertW'(i) != in_excl);
    end
  end

  // ---------------- scan unit ----------------
  assign cand = rd_row & allowed_q & ~visited_q;

  gsr_ffs u_ffs (
    .cand_i  (cand),
    .found_o (found),
    .idx_o   (w)
  );

  assign out_free = !out_vld_q || m_axis_tready;
  assign push     = (st_q == ST_SCAN) && found && out_free;
  assign last_pop = (depth_q == gsr_pkg::DepthW'(1));

  // ---------------- adjacency memory ----------------
  always_comb begin
    req         = '0;
    req.rd_addr = ea_q;
    req.wr_addr = ea_q;
    case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          req.clear = (in_op == gsr_pkg::OP_CLEAR);
          if (in_op == gsr_pkg::OP_DIVIDE) begin
            req.re      = 1'b1;
            req.rd_addr = in_start;
          end else if (in_op == gsr_pkg::OP_ADD_EDGE && in_range) begin
            req.re      = 1'b1;
            req.rd_addr = in_a;
          end
        end
      end
      ST_EA_WR: begin
        req.we      = 1'b1;
        req.wr_addr = ea_q;
        req.wr_data = rd_row | (gsr_pkg::row_t'(1) << eb_q);
      end
      ST_EB_RD: begin
        req.re      = 1'b1;
        req.rd_addr = eb_q;
      end
      ST_EB_WR: begin
        req.we      = 1'b1;
        req.wr_addr = eb_q;
        req.wr_data = rd_row | (gsr_pkg::row_t'(1) << ea_q);
      end
      ST_SCAN: begin
        req.re      = push;
        req.rd_addr = w;
      end
      ST_POP: begin
        req.re      = 1'b1;
        req.rd_addr = stack_rd_q;
      end
      default: begin
        req.re = 1'b0;
      end
    endcase
  end

  gsr_adj_mem u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_row_o (rd_row)
  );

  // ---------------- walk stack ----------------
  assign pop_depth = depth_q - gsr_pkg::DepthW'(2);

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = in_start;
    stk_re    = 1'b0;
    stk_raddr = pop_depth[gsr_pkg::VertW-1:0];
    if (st_q == ST_IDLE) begin
      stk_we = s_acc && (in_op == gsr_pkg::OP_DIVIDE);
    end else if (st_q == ST_SCAN) begin
      stk_we    = push;
      stk_waddr = depth_q[gsr_pkg::VertW-1:0];
      stk_wdata = w;
      stk_re    = !found && !last_pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_q[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stack_rd_q <= stack_q[stk_raddr];
    end
  end

  // ---------------- sequencer and output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      depth_q    <= '0;
      visited_q  <= '0;
      allowed_q  <= '0;
      ea_q       <= '0;
      eb_q       <= '0;
      pend_q     <= '0;
      start_q    <= '0;
      excl_q     <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_vert_q <= '0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (in_op == gsr_pkg::OP_ADD_EDGE && in_range) begin
              ea_q <= in_a;
              eb_q <= in_b;
              st_q <= ST_EA_WR;
            end else if (in_op == gsr_pkg::OP_DIVIDE) begin
              visited_q <= gsr_pkg::row_t'(1) << in_start;
              allowed_q <= allowed_d;
              pend_q    <= in_start;
              start_q   <= in_start;
              excl_q    <= in_excl;
              depth_q   <= gsr_pkg::DepthW'(1);
              st_q      <= ST_SCAN;
            end
          end
        end
        ST_EA_WR: st_q <= ST_EB_RD;
        ST_EB_RD: st_q <= ST_EB_WR;
        ST_EB_WR: st_q <= ST_IDLE;
        ST_SCAN: begin
          if (found) begin
            if (out_free) begin
              visited_q <= visited_q | (gsr_pkg::row_t'(1) << w);
              pend_q    <= w;
              depth_q   <= depth_q + gsr_pkg::DepthW'(1);
            end
          end else if (last_pop) begin
            depth_q <= '0;
            st_q    <= ST_FIN;
          end else begin
            depth_q <= depth_q - gsr_pkg::DepthW'(1);
            st_q    <= ST_POP;
          end
        end
        ST_POP: st_q <= ST_SCAN;
        ST_FIN: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase

      // the previous vertex leaves only once the next one is known, so the
      // final one can carry tlast
      if (push || (st_q == ST_FIN && out_free)) begin
        out_vld_q  <= 1'b1;
        out_last_q <= (st_q == ST_FIN);
        out_vert_q <= pend_q;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_vert_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------- assertions ----------------
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= gsr_pkg::DepthW'(gsr_pkg::MaxVertices))
    else $error("walk stack overflow");

  a_excl_never_entered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (!visited_q[excl_q] || (excl_q == start_q)))
    else $error("excluded vertex entered");

  a_pend_visited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> visited_q[pend_q])
    else $error("pending vertex not marked visited");

  a_push_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (depth_q == $past(depth_q) + gsr_pkg::DepthW'(1)))
    else $error("push did not grow stack");

endmodule
